>>> hw/rtl/blfg_pkg.sv
package blfg_pkg;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_QOS_CAP   = 2'd1,
      CSR_MIN_FREQ  = 2'd2,
      CSR_MAX_FREQ  = 2'd3
   } csr_index_type;

   localparam logic [6:0]  DEFAULT_THRESHOLD = 7'd30;
   localparam logic [6:0]  PERCENT_SCALE     = 7'd100;
   localparam int          LARGE_COUNT_BIT   = 24;
   localparam logic [63:0] SAT_LIMIT         = 64'hFFFF_FFFF_FFFF_FFFF / 64'd100;

   // word sideband carried past the first divider
   typedef struct packed {
      logic        fallback;
      logic [31:0] fallback_freq;
      logic [31:0] qos_min;
   } side_type;

   // sideband carried past the second divider
   typedef struct packed {
      logic     saturated;
      side_type side;
   } side2_type;

endpackage

>>> hw/rtl/blfg_div.sv
module blfg_div #(
   parameter int DVD_W  = 64,
   parameter int DVS_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  in_dividend,
   input  logic [DVS_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DVD_W-1:0]  out_quotient,
   output logic [SIDE_W-1:0] out_side
);

   // one quotient bit per stage, restoring
   logic              vld_ff  [DVD_W];
   logic [DVS_W-1:0]  rem_ff  [DVD_W];
   logic [DVD_W-1:0]  dvd_ff  [DVD_W];
   logic [DVS_W-1:0]  dvs_ff  [DVD_W];
   logic [SIDE_W-1:0] side_ff [DVD_W];

   logic              vld_src  [DVD_W];
   logic [DVS_W-1:0]  rem_src  [DVD_W];
   logic [DVD_W-1:0]  dvd_src  [DVD_W];
   logic [DVS_W-1:0]  dvs_src  [DVD_W];
   logic [SIDE_W-1:0] side_src [DVD_W];

   genvar k;
   generate
      for (k = 0; k < DVD_W; k++) begin : g_stage
         logic [DVS_W:0]   trial;
         logic             ge;
         logic [DVS_W-1:0] rem_in;
         logic [DVD_W-1:0] dvd_in;

         if (k == 0) begin : g_first
            assign vld_src[k]  = in_valid;
            assign rem_src[k]  = '0;
            assign dvd_src[k]  = in_dividend;
            assign dvs_src[k]  = in_divisor;
            assign side_src[k] = in_side;
         end else begin : g_next
            assign vld_src[k]  = vld_ff[k-1];
            assign rem_src[k]  = rem_ff[k-1];
            assign dvd_src[k]  = dvd_ff[k-1];
            assign dvs_src[k]  = dvs_ff[k-1];
            assign side_src[k] = side_ff[k-1];
         end

         always_comb begin
            trial  = {rem_src[k], dvd_src[k][DVD_W-1]};
            ge     = (trial >= {1'b0, dvs_src[k]});
            rem_in = ge ? DVS_W'(trial - {1'b0, dvs_src[k]}) : trial[DVS_W-1:0];
            dvd_in = {dvd_src[k][DVD_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_src[k];
            end
            rem_ff[k]  <= rem_in;
            dvd_ff[k]  <= dvd_in;
            dvs_ff[k]  <= dvs_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   endgenerate

   assign out_valid    = vld_ff[DVD_W-1];
   assign out_quotient = dvd_ff[DVD_W-1];
   assign out_side     = side_ff[DVD_W-1];

endmodule

>>> hw/rtl/bus_load_frequency_governor.sv
// channel   ports                               handshake
// request   req_busy_count .. req_qos_min_freq  start high, busy low
// response  rsp_target_freq                     rsp_valid, one cycle
// config    csr_index, csr_write_data           csr_write_enable
//
// a word enters every cycle; it passes prescale and product registers, then
// the two 64-stage restoring dividers (busy*current/total, then x100/threshold)
// reset is synchronous and clears the valid bits and the config registers
// busy stays low: the pipeline always advances and the receiver cannot stall
module bus_load_frequency_governor #(
   parameter int FREQ_WIDTH     = 32,
   parameter int PRESCALE_SHIFT = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [31:0]            req_busy_count,
   input  logic [31:0]            req_total_count,
   input  logic [31:0]            req_current_freq,
   input  logic [31:0]            req_qos_min_freq,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_target_freq,
   input  logic                   csr_write_enable,
   input  blfg_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_write_data
);
   import blfg_pkg::*;

   localparam logic [63:0] FREQ_MASK = {64{1'b1}} >> (64 - FREQ_WIDTH);

   logic [6:0]  threshold_ff;
   logic [31:0] qos_cap_ff, min_freq_ff, max_freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         qos_cap_ff   <= '0;
         min_freq_ff  <= '0;
         max_freq_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_write_data[6:0];
            CSR_QOS_CAP:   qos_cap_ff   <= csr_write_data;
            CSR_MIN_FREQ:  min_freq_ff  <= csr_write_data;
            CSR_MAX_FREQ:  max_freq_ff  <= csr_write_data;
            default:       ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 0: prescale, fallback decision
   logic        accept;
   logic        big_count;
   logic [31:0] busy_sh, total_sh;
   logic [31:0] fb_in;
   logic        s0_vld_ff;
   logic [31:0] s0_busy_ff, s0_total_ff, s0_cur_ff;
   side_type    s0_side_ff;

   assign accept = start && !busy;

   always_comb begin
      big_count = (|req_busy_count[31:LARGE_COUNT_BIT]) ||
                  (|req_total_count[31:LARGE_COUNT_BIT]);
      busy_sh  = big_count ? (req_busy_count >> PRESCALE_SHIFT) : req_busy_count;
      total_sh = big_count ? (req_total_count >> PRESCALE_SHIFT) : req_total_count;
      if (qos_cap_ff != '0) begin
         fb_in = max_freq_ff;
         if (qos_cap_ff > fb_in) fb_in = qos_cap_ff;
         if (req_qos_min_freq > fb_in) fb_in = req_qos_min_freq;
      end else begin
         fb_in = (max_freq_ff != '0) ? max_freq_ff : FREQ_MASK[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= accept;
      end
      s0_busy_ff               <= busy_sh;
      s0_total_ff              <= total_sh;
      s0_cur_ff                <= req_current_freq;
      s0_side_ff.fallback      <= (total_sh == '0) || (req_current_freq == '0);
      s0_side_ff.fallback_freq <= fb_in;
      s0_side_ff.qos_min       <= req_qos_min_freq;
   end

   // stage 1: product
   logic        s1_vld_ff;
   logic [63:0] s1_prod_ff;
   logic [31:0] s1_total_ff;
   side_type    s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_prod_ff  <= 64'(s0_busy_ff) * 64'(s0_cur_ff);
      s1_total_ff <= s0_total_ff;
      s1_side_ff  <= s0_side_ff;
   end

   logic        d1_vld;
   logic [63:0] d1_quo;
   side_type    d1_side;

   blfg_div #(.DVD_W(64), .DVS_W(32), .SIDE_W($bits(side_type))) u_div_total (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_vld_ff),
      .in_dividend  (s1_prod_ff),
      .in_divisor   (s1_total_ff),
      .in_side      (s1_side_ff),
      .out_valid    (d1_vld),
      .out_quotient (d1_quo),
      .out_side     (d1_side)
   );

   // scale by percent
   logic        s2_vld_ff;
   logic [63:0] s2_scaled_ff;
   side2_type   s2_side_ff;
   logic [6:0]  thr;

   assign thr = (threshold_ff != '0) ? threshold_ff : DEFAULT_THRESHOLD;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= d1_vld;
      end
      s2_scaled_ff         <= 64'(d1_quo * 64'(PERCENT_SCALE));
      s2_side_ff.saturated <= (d1_quo > SAT_LIMIT);
      s2_side_ff.side      <= d1_side;
   end

   logic        d2_vld;
   logic [63:0] d2_quo;
   side2_type   d2_side;

   blfg_div #(.DVD_W(64), .DVS_W(7), .SIDE_W($bits(side2_type))) u_div_thr (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_vld_ff),
      .in_dividend  (s2_scaled_ff),
      .in_divisor   (thr),
      .in_side      (s2_side_ff),
      .out_valid    (d2_vld),
      .out_quotient (d2_quo),
      .out_side     (d2_side)
   );

   // clamp stage a: qos cap and width saturation
   logic [63:0] ca_in;
   logic        ca_vld_ff;
   logic [63:0] ca_t_ff;
   side_type    ca_side_ff;

   always_comb begin
      ca_in = d2_side.saturated ? {64{1'b1}} : d2_quo;
      if ((qos_cap_ff != '0) && (ca_in > 64'(qos_cap_ff))) ca_in = 64'(qos_cap_ff);
      if (ca_in > FREQ_MASK) ca_in = FREQ_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_vld_ff <= 1'b0;
      end else begin
         ca_vld_ff <= d2_vld;
      end
      ca_t_ff    <= ca_in;
      ca_side_ff <= d2_side.side;
   end

   // clamp stage b: qos minimum
   logic [63:0] cb_in;
   logic        cb_vld_ff;
   logic [63:0] cb_t_ff;
   side_type    cb_side_ff;

   always_comb begin
      cb_in = ca_t_ff;
      if ((ca_side_ff.qos_min != '0) && (64'(ca_side_ff.qos_min) > cb_in)) begin
         cb_in = 64'(ca_side_ff.qos_min);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_vld_ff <= 1'b0;
      end else begin
         cb_vld_ff <= ca_vld_ff;
      end
      cb_t_ff    <= cb_in;
      cb_side_ff <= ca_side_ff;
   end

   // clamp stage c: min and max limits, fallback select
   logic [63:0] cc_t;
   logic [31:0] target_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_target_ff;

   always_comb begin
      cc_t = cb_t_ff;
      if ((min_freq_ff != '0) && (cc_t < 64'(min_freq_ff))) cc_t = 64'(min_freq_ff);
      if ((max_freq_ff != '0) && (cc_t > 64'(max_freq_ff))) cc_t = 64'(max_freq_ff);
      target_in = cb_side_ff.fallback ? cb_side_ff.fallback_freq : cc_t[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cb_vld_ff;
      end
      rsp_target_ff <= target_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_freq = rsp_target_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import blfg_pkg::*;

   typedef struct {
      logic [31:0] busy_cnt;
      logic [31:0] total_cnt;
      logic [31:0] cur_freq;
      logic [31:0] qos_min;
   } sample_type;

   localparam int LATENCY = 134;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [31:0] req_busy_count = '0;
   logic [31:0] req_total_count = '0;
   logic [31:0] req_current_freq = '0;
   logic [31:0] req_qos_min_freq = '0;
   logic        rsp_valid;
   logic [31:0] rsp_target_freq;
   logic        csr_write_enable = 0;
   csr_index_type csr_index = CSR_THRESHOLD;
   logic [31:0] csr_write_data = '0;

   // governor settings as the predictor sees them
   logic [6:0]  gov_threshold = '0;
   logic [31:0] gov_qos_cap = '0;
   logic [31:0] gov_min_freq = '0;
   logic [31:0] gov_max_freq = '0;

   sample_type  pending_samples[$];
   logic [31:0] expected_freqs[$];
   int          error_count = 0;
   int          sent_count = 0;
   int          checked_count = 0;
   int          idle_cycles = 0;
   bit          idling_on = 1;
   int          gap_left = 0;

   always #2 clock = ~clock;

   bus_load_frequency_governor i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_busy_count(req_busy_count), .req_total_count(req_total_count),
      .req_current_freq(req_current_freq), .req_qos_min_freq(req_qos_min_freq),
      .rsp_valid(rsp_valid), .rsp_target_freq(rsp_target_freq),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   function automatic logic [31:0] fallback_freq(logic [31:0] qos_min);
      logic [31:0] lim;
      lim = (gov_max_freq != 0) ? gov_max_freq : 32'hFFFF_FFFF;
      if (gov_qos_cap != 0) begin
         lim = gov_max_freq;
         if (gov_qos_cap > lim) lim = gov_qos_cap;
         if (qos_min > lim) lim = qos_min;
      end
      return lim;
   endfunction

   function automatic logic [31:0] target_freq(sample_type s);
      logic [63:0] b, tot, t, thr;
      b = {32'd0, s.busy_cnt};
      tot = {32'd0, s.total_cnt};
      thr = (gov_threshold != 0) ? {57'd0, gov_threshold} : 64'd30;
      if (tot == 0) return fallback_freq(s.qos_min);
      if (b >= 64'd1 << 24 || tot >= 64'd1 << 24) begin
         b = b >> 7;
         tot = tot >> 7;
      end
      if (tot == 0 || s.cur_freq == 0) return fallback_freq(s.qos_min);
      t = (b * {32'd0, s.cur_freq}) / tot;
      if (t > 64'hFFFF_FFFF_FFFF_FFFF / 64'd100) t = '1;
      else t = (t * 64'd100) / thr;
      if (gov_qos_cap != 0 && t > {32'd0, gov_qos_cap}) t = {32'd0, gov_qos_cap};
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      if (s.qos_min != 0 && {32'd0, s.qos_min} > t) t = {32'd0, s.qos_min};
      if (gov_min_freq != 0 && t < {32'd0, gov_min_freq}) t = {32'd0, gov_min_freq};
      if (gov_max_freq != 0 && t > {32'd0, gov_max_freq}) t = {32'd0, gov_max_freq};
      return t[31:0];
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) begin
            expected_freqs.push_back(target_freq('{req_busy_count, req_total_count,
               req_current_freq, req_qos_min_freq}));
            sent_count++;
         end
         if (start && busy) begin
            // hold the word until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 4);
            start <= 0;
         end else if (pending_samples.size() > 0) begin
            sample_type s;
            s = pending_samples.pop_front();
            req_busy_count <= s.busy_cnt;
            req_total_count <= s.total_cnt;
            req_current_freq <= s.cur_freq;
            req_qos_min_freq <= s.qos_min;
            start <= 1;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_freqs.size() == 0) begin
            $display("%0t: unexpected target_freq %h", $time, rsp_target_freq);
            error_count++;
         end else begin
            logic [31:0] exp_freq;
            exp_freq = expected_freqs.pop_front();
            checked_count++;
            if (rsp_target_freq !== exp_freq) begin
               $display("%0t: target_freq expected %h actual %h", $time, exp_freq,
                  rsp_target_freq);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset || csr_write_enable) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_THRESHOLD: gov_threshold = data[6:0];
         CSR_QOS_CAP:   gov_qos_cap = data;
         CSR_MIN_FREQ:  gov_min_freq = data;
         CSR_MAX_FREQ:  gov_max_freq = data;
      endcase
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain();
      wait (pending_samples.size() == 0 && !start && gap_left == 0);
      wait (expected_freqs.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic add_sample(logic [31:0] b, logic [31:0] t, logic [31:0] c,
                             logic [31:0] q);
      pending_samples.push_back('{b, t, c, q});
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 1 << 16);
         3: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n);
      sample_type s;
      repeat (n) begin
         s.busy_cnt = rand_word();
         s.total_cnt = rand_word();
         // mostly realistic windows: busy within total
         if ($urandom_range(0, 3) != 0 && s.busy_cnt > s.total_cnt)
            s.busy_cnt = s.total_cnt == 0 ? 0 : $urandom_range(0, s.total_cnt);
         s.cur_freq = rand_word();
         s.qos_min = ($urandom_range(0, 2) == 0) ? 32'd0 : rand_word();
         pending_samples.push_back(s);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: defaults, empty window, unknown freq, prescale, huge target
      add_sample(32'd50, 32'd100, 32'd1000, 32'd0);
      add_sample(32'd10, 32'd0, 32'd1000, 32'd5);
      add_sample(32'd10, 32'd100, 32'd0, 32'd5);
      add_sample(32'h0100_0000, 32'h0200_0000, 32'd800, 32'd0);
      add_sample(32'd5, 32'h0000_007F, 32'd800, 32'd0);
      add_sample(32'd1, 32'h0100_0000, 32'd800, 32'd0);
      add_sample(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
      add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_sample(32'd0, 32'd1, 32'd1, 32'd7);
      add_sample(32'd0, 32'h0000_0001, 32'h0000_0001, 32'd0);
      drain();

      write_csr(CSR_THRESHOLD, 32'd127);
      write_csr(CSR_QOS_CAP, 32'd5000);
      write_csr(CSR_MIN_FREQ, 32'd100);
      write_csr(CSR_MAX_FREQ, 32'd3000);
      add_sample(32'd10, 32'd0, 32'd1000, 32'd9000);
      add_sample(32'd10, 32'd0, 32'd1000, 32'd0);
      add_sample(32'd90, 32'd100, 32'd100000, 32'd0);
      add_sample(32'd1, 32'd100, 32'd1, 32'd0);
      add_sample(32'd1, 32'd100, 32'd1, 32'd4000);
      add_sample(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
      drain();
      write_csr(CSR_THRESHOLD, 32'd0);

      write_csr(CSR_THRESHOLD, 32'd1);
      write_csr(CSR_MAX_FREQ, 32'd0);
      add_sample(32'd10, 32'd0, 32'd1, 32'd0);
      add_sample(32'd10, 32'd0, 32'd1, 32'd20000);
      add_sample(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
      drain();

      // random phases over several settings
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_THRESHOLD, (phase == 0) ? 32'd0 : (phase == 1) ? 32'd100 :
            (phase == 2) ? 32'd127 : $urandom_range(1, 127));
         write_csr(CSR_QOS_CAP, (phase % 2 == 0) ? 32'd0 :
            (phase == 3) ? 32'hFFFF_FFFF : rand_word());
         write_csr(CSR_MIN_FREQ, (phase < 2) ? 32'd0 : (phase == 5) ? 32'hFFFF_FFFF :
            rand_word());
         write_csr(CSR_MAX_FREQ, (phase == 0) ? 32'd0 : (phase == 4) ? 32'hFFFF_FFFF :
            rand_word());
         if (phase == 5) idling_on = 0;
         random_phase(120);
         drain();
      end

      $display("checked %0d targets from %0d samples over six register settings",
         checked_count, sent_count);
      $display("covered fallback, prescale, saturation, qos and clamp paths");
      if (error_count == 0 && expected_freqs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
